FILE: rtl/aegs_pkg.sv
`timescale 1ns / 1ps

package aegs_pkg;

   // field widths
   localparam int CountW   = 32;
   localparam int SumW     = 48;
   localparam int TargetW  = 8;
   localparam int ValW     = 16;
   localparam int DgW      = 8;
   localparam int RatioW   = 6;
   localparam int FracW    = 4;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 16;

   // derived widths
   localparam int ProdW    = CountW + TargetW;
   localparam int NumW     = SumW + 1;
   localparam int DivCntW  = $clog2(NumW + 1);
   localparam int ProdVW   = ValW + RatioW;
   localparam int StepW    = ProdVW - FracW;
   localparam int ReqDataW = 80;
   localparam int RspDataW = 48;

   // ratio thresholds, 2.4 format
   localparam logic [RatioW-1:0] RATIO_MAX   = 6'd32;
   localparam logic [RatioW-1:0] RAISE_ABOVE = 6'd18;
   localparam logic [RatioW-1:0] LOWER_BELOW = 6'd14;

   // bounds and reset values
   localparam logic [DgW-1:0]  DGAIN_MAX      = 8'hff;
   localparam logic [ValW-1:0] EXPOSURE_RESET = 16'h080;
   localparam logic [ValW-1:0] GAIN_UNITY     = 16'h010;
   localparam logic [ValW-1:0] EXPOSURE_MIN   = 16'd1;
   localparam logic [DgW-1:0]  DGAIN_UNITY    = 8'h10;

   // configuration register reset values
   localparam logic [TargetW-1:0] TARGET_RESET   = 8'd128;
   localparam logic [ValW-1:0]    EXP_LIM_RESET  = 16'd1024;
   localparam logic [ValW-1:0]    GAIN_LIM_RESET = 16'd256;

   // configuration register indexes
   localparam logic [CsrAddrW-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_EXP_LIM  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_GAIN_LIM = 2'd2;

   // which value moves this frame
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_EXP,
      SEL_GAIN,
      SEL_DGAIN
   } sel_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic form_num;
      logic div_start;
      logic select;
      logic mult;
      logic step;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/aegs_div.sv
`timescale 1ns / 1ps

module aegs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aegs_pkg::NumW-1:0]     num,
   input  logic [aegs_pkg::SumW-1:0]     den,
   output logic                          done,
   output logic [aegs_pkg::RatioW-1:0]   quo,
   output logic                          big
);
   import aegs_pkg::*;

   logic [SumW-1:0]    rem_ff;
   logic [NumW-1:0]    num_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [RatioW-1:0]  q_ff;
   logic               big_ff;

   logic [NumW-1:0]    trial;
   logic [NumW-1:0]    diff;
   logic               ge;
   logic [SumW-1:0]    rem_in;

   // one restoring step per cycle
   always_comb begin
      trial  = {rem_ff, num_ff[NumW-1]};
      ge     = trial >= {1'b0, den};
      diff   = trial - {1'b0, den};
      rem_in = ge ? diff[SumW-1:0] : trial[SumW-1:0];
   end

   // control of the iteration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DivCntW'(1);
         if (cnt_ff == DivCntW'(NumW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // remainder, dividend shifter and quotient with overflow flag
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= num;
         q_ff   <= '0;
         big_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[NumW-2:0], 1'b0};
         q_ff   <= {q_ff[RatioW-2:0], ge};
         big_ff <= big_ff | q_ff[RatioW-1];
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign big  = big_ff;

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done at once");

endmodule

FILE: rtl/aegs_dp.sv
`timescale 1ns / 1ps

module aegs_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  aegs_pkg::cmd_type               cmd,
   output aegs_pkg::status_type            status,
   input  logic [aegs_pkg::CountW-1:0]     pixel_count,
   input  logic [aegs_pkg::SumW-1:0]       luma_sum,
   input  logic                            csr_we,
   input  logic [aegs_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [aegs_pkg::CsrDataW-1:0]   csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [aegs_pkg::ValW-1:0]       exposure_out,
   output logic [aegs_pkg::ValW-1:0]       sensor_gain_out,
   output logic [aegs_pkg::DgW-1:0]        digital_gain_out,
   output logic                            exposure_changed,
   output logic                            sensor_gain_changed,
   output logic                            digital_gain_changed
);
   import aegs_pkg::*;

   // configuration
   logic [TargetW-1:0] target_ff;
   logic [ValW-1:0]    exp_lim_ff;
   logic [ValW-1:0]    gain_lim_ff;

   // frame to frame state
   logic [ValW-1:0]    exp_ff;
   logic [ValW-1:0]    gain_ff;
   logic [DgW-1:0]     dg_ff;

   // per item working registers
   logic [ProdW-1:0]   prod_ff;
   logic [SumW-1:0]    sum_ff;
   logic               sum_zero_ff;
   logic [NumW-1:0]    num_ff;
   logic [RatioW-1:0]  ratio_ff;
   sel_type            sel_ff;
   logic               up_ff;
   logic [ValW-1:0]    v_ff;
   logic [ValW-1:0]    lim_ff;
   logic [ProdVW-1:0]  prod_v_ff;
   logic [StepW-1:0]   d_ff;

   // result register
   logic               rsp_valid_ff;
   logic [ValW-1:0]    rsp_exp_ff;
   logic [ValW-1:0]    rsp_gain_ff;
   logic [DgW-1:0]     rsp_dg_ff;
   logic               rsp_exp_chg_ff;
   logic               rsp_gain_chg_ff;
   logic               rsp_dg_chg_ff;

   logic               div_done;
   logic [RatioW-1:0]  div_quo;
   logic               div_big;

   logic [NumW-1:0]    num_in;
   logic [RatioW-1:0]  ratio_in;
   sel_type            sel_in;
   logic               up_in;
   logic [ValW-1:0]    v_in;
   logic [ValW-1:0]    lim_in;
   logic [StepW-1:0]   scaled;
   logic [StepW-1:0]   diff;
   logic [StepW-1:0]   half;
   logic [StepW-1:0]   d_in;
   logic [StepW-1:0]   up_sum;
   logic [StepW-1:0]   down_lo;
   logic [ValW-1:0]    new_in;
   logic [ValW-1:0]    exp_in;
   logic [ValW-1:0]    gain_in;
   logic [DgW-1:0]     dg_in;

   // configuration writes, other indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         exp_lim_ff  <= EXP_LIM_RESET;
         gain_lim_ff <= GAIN_LIM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TARGET:   target_ff   <= csr_wdata[TargetW-1:0];
            CSR_EXP_LIM:  exp_lim_ff  <= csr_wdata[ValW-1:0];
            CSR_GAIN_LIM: gain_lim_ff <= csr_wdata[ValW-1:0];
            default:      ;
         endcase
      end
   end

   // numerator: count * target * 16 + sum / 2
   assign num_in = NumW'({prod_ff, {FracW{1'b0}}}) + NumW'(sum_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_ff     <= ProdW'(pixel_count) * ProdW'(target_ff);
         sum_ff      <= luma_sum;
         sum_zero_ff <= (luma_sum == '0);
      end
      if (cmd.form_num) begin
         num_ff <= num_in;
      end
   end

   aegs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (sum_ff),
      .done  (div_done),
      .quo   (div_quo),
      .big   (div_big)
   );

   // clamped ratio and choice of the value to move
   always_comb begin
      if (sum_zero_ff || div_big || (div_quo > RATIO_MAX)) begin
         ratio_in = RATIO_MAX;
      end else begin
         ratio_in = div_quo;
      end
      sel_in = SEL_NONE;
      up_in  = 1'b0;
      v_in   = exp_ff;
      lim_in = exp_lim_ff;
      priority if (ratio_in > RAISE_ABOVE) begin
         up_in = 1'b1;
         priority if (exp_ff < exp_lim_ff) begin
            sel_in = SEL_EXP;
            v_in   = exp_ff;
            lim_in = exp_lim_ff;
         end else if (gain_ff < gain_lim_ff) begin
            sel_in = SEL_GAIN;
            v_in   = gain_ff;
            lim_in = gain_lim_ff;
         end else if (dg_ff < DGAIN_MAX) begin
            sel_in = SEL_DGAIN;
            v_in   = ValW'(dg_ff);
            lim_in = ValW'(DGAIN_MAX);
         end else begin
            // every value at its upper bound
            sel_in = SEL_NONE;
         end
      end else if (ratio_in < LOWER_BELOW) begin
         priority if (dg_ff > DGAIN_UNITY) begin
            sel_in = SEL_DGAIN;
            v_in   = ValW'(dg_ff);
            lim_in = GAIN_UNITY;
         end else if (gain_ff > GAIN_UNITY) begin
            sel_in = SEL_GAIN;
            v_in   = gain_ff;
            lim_in = GAIN_UNITY;
         end else if (exp_ff > EXPOSURE_MIN) begin
            sel_in = SEL_EXP;
            v_in   = exp_ff;
            lim_in = EXPOSURE_MIN;
         end else begin
            // every value at its floor
            sel_in = SEL_NONE;
         end
      end else begin
         // hold band, nothing moves
         sel_in = SEL_NONE;
      end
   end

   // step size: max(1, |v*ratio>>4 - v| >> 1)
   always_comb begin
      scaled = prod_v_ff[ProdVW-1:FracW];
      if (up_ff) begin
         diff = scaled - StepW'(v_ff);
      end else begin
         diff = StepW'(v_ff) - scaled;
      end
      half = diff >> 1;
      d_in = (half == '0) ? StepW'(1) : half;
   end

   // clamped new value and its placement
   always_comb begin
      up_sum  = StepW'(v_ff) + d_ff;
      down_lo = StepW'(lim_ff) + d_ff;
      if (up_ff) begin
         new_in = (up_sum > StepW'(lim_ff)) ? lim_ff : up_sum[ValW-1:0];
      end else begin
         new_in = (StepW'(v_ff) < down_lo) ? lim_ff : (v_ff - d_ff[ValW-1:0]);
      end
      exp_in  = (sel_ff == SEL_EXP)   ? new_in : exp_ff;
      gain_in = (sel_ff == SEL_GAIN)  ? new_in : gain_ff;
      dg_in   = (sel_ff == SEL_DGAIN) ? new_in[DgW-1:0] : dg_ff;
   end

   // working registers of the update
   always_ff @(posedge clock) begin
      if (cmd.select) begin
         ratio_ff <= ratio_in;
         sel_ff   <= sel_in;
         up_ff    <= up_in;
         v_ff     <= v_in;
         lim_ff   <= lim_in;
      end
      if (cmd.mult) begin
         prod_v_ff <= ProdVW'(v_ff) * ProdVW'(ratio_ff);
      end
      if (cmd.step) begin
         d_ff <= d_in;
      end
   end

   // exposure and gain state
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= EXPOSURE_RESET;
         gain_ff <= GAIN_UNITY;
         dg_ff   <= DGAIN_UNITY;
      end else if (cmd.apply) begin
         exp_ff  <= exp_in;
         gain_ff <= gain_in;
         dg_ff   <= dg_in;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_exp_ff      <= exp_in;
         rsp_gain_ff     <= gain_in;
         rsp_dg_ff       <= dg_in;
         rsp_exp_chg_ff  <= (exp_in != exp_ff);
         rsp_gain_chg_ff <= (gain_in != gain_ff);
         rsp_dg_chg_ff   <= (dg_in != dg_ff);
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign exposure_out         = rsp_exp_ff;
   assign sensor_gain_out      = rsp_gain_ff;
   assign digital_gain_out     = rsp_dg_ff;
   assign exposure_changed     = rsp_exp_chg_ff;
   assign sensor_gain_changed  = rsp_gain_chg_ff;
   assign digital_gain_changed = rsp_dg_chg_ff;

   a_exp_nonzero: assert property (@(posedge clock) disable iff (reset)
      exp_ff != '0)
      else $error("exposure dropped to zero");

   a_gains_floor: assert property (@(posedge clock) disable iff (reset)
      (gain_ff >= GAIN_UNITY) && (dg_ff >= DGAIN_UNITY))
      else $error("gain below unity");

   a_one_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_exp_chg_ff, rsp_gain_chg_ff, rsp_dg_chg_ff}))
      else $error("more than one value changed in a frame");

endmodule

FILE: rtl/aegs_ctrl.sv
`timescale 1ns / 1ps

module aegs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  aegs_pkg::status_type  status,
   output aegs_pkg::cmd_type     cmd
);
   import aegs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NUM,
      S_DIV_START,
      S_DIV_WAIT,
      S_SELECT,
      S_MULT,
      S_STEP,
      S_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            cmd.form_num = 1'b1;
            state_in     = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_SELECT;
            end
         end
         S_SELECT: begin
            cmd.select = 1'b1;
            state_in   = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: rtl/auto_exposure_gain_stepper_top.sv
`timescale 1ns / 1ps
// a valid response beat follows each accepted request beat, delayed further only while
// the response register still holds an untaken beat
// one frame at a time, each through the 49-step restoring divider
// reset (synchronous, active high): target 128, exposure limit 1024, gain limit 256,
// exposure 128, sensor gain 16, digital gain 16, no response pending

module auto_exposure_gain_stepper_top (
   input  logic                              clock,
   input  logic                              reset,
   // pixel_count [31:0], luma_sum [79:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [aegs_pkg::ReqDataW-1:0]     req_tdata,
   // exposure_out [15:0], sensor_gain_out [31:16], digital_gain_out [39:32],
   // exposure_changed [40], sensor_gain_changed [41], digital_gain_changed [42]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [aegs_pkg::RspDataW-1:0]     rsp_tdata,
   input  logic                              csr_we,
   input  logic [aegs_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [aegs_pkg::CsrDataW-1:0]     csr_wdata
);
   import aegs_pkg::*;

   cmd_type         cmd;
   status_type      status;
   logic [ValW-1:0] exposure_out;
   logic [ValW-1:0] sensor_gain_out;
   logic [DgW-1:0]  digital_gain_out;
   logic            exposure_changed;
   logic            sensor_gain_changed;
   logic            digital_gain_changed;

   aegs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   aegs_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .pixel_count          (req_tdata[CountW-1:0]),
      .luma_sum             (req_tdata[CountW+SumW-1:CountW]),
      .csr_we               (csr_we),
      .csr_addr             (csr_addr),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_tvalid),
      .rsp_ready            (rsp_tready),
      .exposure_out         (exposure_out),
      .sensor_gain_out      (sensor_gain_out),
      .digital_gain_out     (digital_gain_out),
      .exposure_changed     (exposure_changed),
      .sensor_gain_changed  (sensor_gain_changed),
      .digital_gain_changed (digital_gain_changed)
   );

   // response beat packing, zero padded to whole bytes
   assign rsp_tdata = RspDataW'({digital_gain_changed, sensor_gain_changed,
                                 exposure_changed, digital_gain_out,
                                 sensor_gain_out, exposure_out});

endmodule
